/* hw/rtl/mdfs_pkg.sv */
// Shared types and constants for the maze depth-first walker.
`default_nettype none

package mdfs_pkg;

   // Position fields are fixed at 5 bits; the grid store follows from them.
   localparam int POS_W    = 5;
   localparam int SIDE_W   = POS_W + 1;
   localparam int MAX_SIDE = 1 << POS_W;
   localparam int CELLS    = MAX_SIDE * MAX_SIDE;
   localparam int STK_AW   = $clog2(CELLS);
   localparam int CNT_W    = STK_AW + 1;

   // Front-to-back queue.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // Register reset values.
   localparam logic [SIDE_W-1:0] SIDE_RST      = SIDE_W'(20);
   localparam logic [POS_W-1:0]  START_ROW_RST = POS_W'(1);
   localparam logic [POS_W-1:0]  START_COL_RST = POS_W'(1);
   localparam logic [POS_W-1:0]  GOAL_ROW_RST  = POS_W'(18);
   localparam logic [POS_W-1:0]  GOAL_COL_RST  = POS_W'(18);

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      REG_MAZE_SIDE = 3'd0,
      REG_START_ROW = 3'd1,
      REG_START_COL = 3'd2,
      REG_GOAL_ROW  = 3'd3,
      REG_GOAL_COL  = 3'd4
   } reg_idx_type;

   // One classified word: free bits indexed by direction, plus the random
   // value already reduced for candidate counts of 2/4 and 3.
   typedef struct packed {
      logic [3:0] free;
      logic [1:0] rnd_lo;
      logic [1:0] rnd_mod3;
   } work_type;

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic [POS_W-1:0]  start_row;
      logic [POS_W-1:0]  start_col;
      logic [POS_W-1:0]  goal_row;
      logic [POS_W-1:0]  goal_col;
      logic              load_row;
      logic              load_col;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/mdfs_fifo.sv */
// Short queue of classified words between the front and the back.
`default_nettype none

module mdfs_fifo
   import mdfs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_word,
   input  wire logic     pop,
   output work_type      head_word,
   output logic          full,
   output logic          empty
);

   work_type            q_mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_word = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/mdfs_front.sv */
// Front end: takes request words and reduces them for the walker.
`default_nettype none

module mdfs_front
   import mdfs_pkg::*;
(
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_free_up,
   input  wire logic       req_free_left,
   input  wire logic       req_free_down,
   input  wire logic       req_free_right,
   input  wire logic [7:0] req_random_value,
   input  wire logic       q_full,
   output logic            q_push,
   output work_type        q_word
);

   // 2-bit digits have weight 4^k, which is 1 mod 3, so sum them first.
   function automatic logic [1:0] mod3_byte(input logic [7:0] v);
      logic [3:0] s;
      logic [3:0] r;
      s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
      priority if (s >= 4'd12) r = s - 4'd12;
      else if (s >= 4'd9)      r = s - 4'd9;
      else if (s >= 4'd6)      r = s - 4'd6;
      else if (s >= 4'd3)      r = s - 4'd3;
      else                     r = s;
      return r[1:0];
   endfunction

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_word.free     = {req_free_right, req_free_down, req_free_left, req_free_up};
      q_word.rnd_lo   = req_random_value[1:0];
      q_word.rnd_mod3 = mod3_byte(req_random_value);
   end

endmodule

`default_nettype wire

/* hw/rtl/mdfs_back.sv */
// Back end: visited map, move stack, position and the result register.
`default_nettype none

module mdfs_back
   import mdfs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire work_type   q_word,
   input  wire logic       q_empty,
   output logic            q_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_move_dir,
   output logic            rsp_moved,
   output logic            rsp_backtracked,
   output logic [POS_W-1:0] rsp_new_row,
   output logic [POS_W-1:0] rsp_new_col,
   output logic            rsp_at_goal,
   output logic            rsp_stuck
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECIDE
   } state_type;

   state_type            state_ff, state_in;
   work_type             item_ff, item_in;
   logic [POS_W-1:0]     row_ff, row_in;
   logic [POS_W-1:0]     col_ff, col_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MAX_SIDE-1:0]  up_word_ff, up_word_in;
   logic [MAX_SIDE-1:0]  down_word_ff, down_word_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_dir_ff, rsp_dir_in;
   logic                 rsp_moved_ff, rsp_moved_in;
   logic                 rsp_bt_ff, rsp_bt_in;
   logic [POS_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]     rsp_col_ff, rsp_col_in;
   logic                 rsp_goal_ff, rsp_goal_in;
   logic                 rsp_stuck_ff, rsp_stuck_in;

   // Visited map: one word per row; a row never written reads as zero.
   logic [MAX_SIDE-1:0]  vis_mem [MAX_SIDE];
   logic [MAX_SIDE-1:0]  vis_valid_ff;
   logic [MAX_SIDE-1:0]  rdata_a_ff, rdata_b_ff;
   logic                 rd_en;
   logic [POS_W-1:0]     addr_a, addr_b;
   logic                 vis_we;
   logic [MAX_SIDE-1:0]  new_word;

   logic [1:0]           stk_mem [CELLS];
   logic [1:0]           stk_rdata_ff;
   logic [CNT_W-1:0]     cnt_dec;
   logic                 stk_re, stk_we;

   // Decide-cycle terms
   logic                 fire;
   logic [SIDE_W-1:0]    side;
   logic [SIDE_W-1:0]    r6, c6;
   logic                 row_ok, col_ok;
   logic [3:0]           in_grid, seen, avail;
   logic [2:0]           n_avail;
   logic [1:0]           pick_idx;
   logic [2:0]           k;
   dir_type              pick;
   logic                 start_at_goal;
   logic                 go_fwd, go_back, is_stuck, moved;
   dir_type              dir;
   logic [POS_W-1:0]     nrow, ncol;
   logic [MAX_SIDE-1:0]  base_word;

   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign fire    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;
   assign rd_en   = q_pop || (state_ff == ST_FETCH);
   assign stk_re  = q_pop;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         addr_a = row_ff - POS_W'(1);
         addr_b = row_ff + POS_W'(1);
      end else begin
         addr_a = row_ff;
         addr_b = row_ff;
      end
   end

   // Candidate classification, valid in ST_DECIDE (rdata_a_ff holds the current row).
   always_comb begin
      side   = (cfg.side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg.side;
      r6     = {1'b0, row_ff};
      c6     = {1'b0, col_ff};
      row_ok = r6 < side;
      col_ok = c6 < side;

      in_grid[DIR_UP]    = (row_ff != '0) && ((r6 - SIDE_W'(1)) < side) && col_ok;
      in_grid[DIR_DOWN]  = ((r6 + SIDE_W'(1)) < side) && col_ok;
      in_grid[DIR_LEFT]  = (col_ff != '0) && ((c6 - SIDE_W'(1)) < side) && row_ok;
      in_grid[DIR_RIGHT] = ((c6 + SIDE_W'(1)) < side) && row_ok;

      seen[DIR_UP]    = up_word_ff[col_ff];
      seen[DIR_DOWN]  = down_word_ff[col_ff];
      seen[DIR_LEFT]  = rdata_a_ff[col_ff - POS_W'(1)];
      seen[DIR_RIGHT] = rdata_a_ff[col_ff + POS_W'(1)];

      avail   = item_ff.free & in_grid & ~seen;
      n_avail = {2'b00, avail[0]} + {2'b00, avail[1]} + {2'b00, avail[2]}
              + {2'b00, avail[3]};

      unique case (n_avail)
         3'd2:    pick_idx = {1'b0, item_ff.rnd_lo[0]};
         3'd3:    pick_idx = item_ff.rnd_mod3;
         3'd4:    pick_idx = item_ff.rnd_lo;
         default: pick_idx = 2'd0;
      endcase

      pick = DIR_UP;
      k    = '0;
      for (int d = 0; d < 4; d++) begin
         if (avail[d]) begin
            if (k == {1'b0, pick_idx}) begin
               pick = dir_type'(2'(d));
            end
            k = k + 3'd1;
         end
      end

      start_at_goal = (row_ff == cfg.goal_row) && (col_ff == cfg.goal_col);
      go_fwd   = !start_at_goal && (n_avail != '0);
      go_back  = !start_at_goal && (n_avail == '0) && (cnt_ff != '0);
      is_stuck = !start_at_goal && (n_avail == '0) && (cnt_ff == '0);
      moved    = go_fwd || go_back;

      // backtrack steps opposite to the popped forward move
      dir = go_fwd ? pick : dir_type'(stk_rdata_ff + 2'd2);

      nrow = row_ff;
      ncol = col_ff;
      unique case (dir)
         DIR_UP:    nrow = row_ff - POS_W'(1);
         DIR_DOWN:  nrow = row_ff + POS_W'(1);
         DIR_LEFT:  ncol = col_ff - POS_W'(1);
         DIR_RIGHT: ncol = col_ff + POS_W'(1);
      endcase

      unique case (dir)
         DIR_UP:    base_word = up_word_ff;
         DIR_DOWN:  base_word = down_word_ff;
         default:   base_word = rdata_a_ff;
      endcase
      new_word = base_word | (MAX_SIDE'(1) << ncol);

      vis_we = fire && moved;
      stk_we = fire && go_fwd && (cnt_ff < CNT_W'(CELLS));
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      up_word_in   = up_word_ff;
      down_word_in = down_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dir_in   = rsp_dir_ff;
      rsp_moved_in = rsp_moved_ff;
      rsp_bt_in    = rsp_bt_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_goal_in  = rsp_goal_ff;
      rsp_stuck_in = rsp_stuck_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               item_in  = q_word;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            up_word_in   = rdata_a_ff;
            down_word_in = rdata_b_ff;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_dir_in   = moved ? dir : DIR_UP;
               rsp_moved_in = moved;
               rsp_bt_in    = go_back;
               rsp_stuck_in = is_stuck;
               if (moved) begin
                  row_in = nrow;
                  col_in = ncol;
               end
               if (stk_we) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else if (go_back) begin
                  cnt_in = cnt_dec;
               end
               rsp_row_in  = moved ? nrow : row_ff;
               rsp_col_in  = moved ? ncol : col_ff;
               rsp_goal_in = moved ? ((nrow == cfg.goal_row) && (ncol == cfg.goal_col))
                                   : start_at_goal;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // the user must make start writes arrive only while idle; the block does not enforce it
      if (cfg.load_row) begin
         row_in = cfg.start_row;
      end
      if (cfg.load_col) begin
         col_in = cfg.start_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= START_ROW_RST;
         col_ff       <= START_COL_RST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      up_word_ff   <= up_word_in;
      down_word_ff <= down_word_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_moved_ff <= rsp_moved_in;
      rsp_bt_ff    <= rsp_bt_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_goal_ff  <= rsp_goal_in;
      rsp_stuck_ff <= rsp_stuck_in;
   end

   // Visited rows
   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[nrow] <= new_word;
      end
      if (rd_en) begin
         rdata_a_ff <= vis_valid_ff[addr_a] ? vis_mem[addr_a] : '0;
         rdata_b_ff <= vis_valid_ff[addr_b] ? vis_mem[addr_b] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_valid_ff <= '0;
      end else if (vis_we) begin
         vis_valid_ff[nrow] <= 1'b1;
      end
   end

   // Move stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_ff[STK_AW-1:0]] <= pick;
      end
      if (stk_re) begin
         stk_rdata_ff <= stk_mem[cnt_dec[STK_AW-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_move_dir    = rsp_dir_ff;
   assign rsp_moved       = rsp_moved_ff;
   assign rsp_backtracked = rsp_bt_ff;
   assign rsp_new_row     = rsp_row_ff;
   assign rsp_new_col     = rsp_col_ff;
   assign rsp_at_goal     = rsp_goal_ff;
   assign rsp_stuck       = rsp_stuck_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CELLS))
      else $error("move stack count beyond capacity");

   a_bt_moved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bt_ff |-> rsp_moved_ff && !rsp_stuck_ff)
      else $error("backtrack word without a move");

   a_stuck_hold: assert property (@(posedge clock) disable iff (reset)
      fire && is_stuck |=> row_ff == $past(row_ff) && col_ff == $past(col_ff)
                           && cnt_ff == $past(cnt_ff))
      else $error("stuck tick changed the walk state");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("decided word did not reach the result register");

endmodule

`default_nettype wire

/* hw/rtl/maze_dfs_solver_step.sv */
// Top level: register port, front end, queue and walker.
// Randomized depth-first maze walker. Each request word carries the four
// wall-free bits of the current cell and a random byte; each yields exactly
// one response word with the move taken and the new position. In the
// walker, the rows above and below the current cell are read from the
// visited map on its two read ports, then the current row, then the move
// is decided and the visited row and the move stack are written. A two-word
// queue in front lets requests be taken while the walker is busy.
// While a response waits in the response register, the walker can already
// take the next word from the queue and read its rows, but it decides the
// move only once the response register is free. The visited map is cleared
// at reset through one valid bit per row, so no clearing pass is needed.
// When no neighbor is free and the stack is empty the word reports stuck and
// the position stays.
// Registers: 0 maze_side, 1 start_row, 2 start_col, 3 goal_row, 4 goal_col at
// byte addresses 4*i; writing a start register also moves the position there.
`default_nettype none

module maze_dfs_solver_step
   import mdfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_free_up,
   input  wire logic        req_free_left,
   input  wire logic        req_free_down,
   input  wire logic        req_free_right,
   input  wire logic [7:0]  req_random_value,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_move_dir,
   output logic             rsp_moved,
   output logic             rsp_backtracked,
   output logic [4:0]       rsp_new_row,
   output logic [4:0]       rsp_new_col,
   output logic             rsp_at_goal,
   output logic             rsp_stuck
);

   logic [SIDE_W-1:0] side_ff;
   logic [POS_W-1:0]  start_row_ff, start_col_ff, goal_row_ff, goal_col_ff;
   logic              wr;
   logic [2:0]        reg_idx;
   cfg_type           cfg;

   logic              q_push, q_pop, q_full, q_empty;
   work_type          front_word, head_word;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SIDE_RST;
         start_row_ff <= START_ROW_RST;
         start_col_ff <= START_COL_RST;
         goal_row_ff  <= GOAL_ROW_RST;
         goal_col_ff  <= GOAL_COL_RST;
      end else if (wr) begin
         unique case (reg_idx)
            REG_MAZE_SIDE: side_ff      <= pwdata[SIDE_W-1:0];
            REG_START_ROW: start_row_ff <= pwdata[POS_W-1:0];
            REG_START_COL: start_col_ff <= pwdata[POS_W-1:0];
            REG_GOAL_ROW:  goal_row_ff  <= pwdata[POS_W-1:0];
            REG_GOAL_COL:  goal_col_ff  <= pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAZE_SIDE: prdata = {{(32-SIDE_W){1'b0}}, side_ff};
         REG_START_ROW: prdata = {{(32-POS_W){1'b0}}, start_row_ff};
         REG_START_COL: prdata = {{(32-POS_W){1'b0}}, start_col_ff};
         REG_GOAL_ROW:  prdata = {{(32-POS_W){1'b0}}, goal_row_ff};
         REG_GOAL_COL:  prdata = {{(32-POS_W){1'b0}}, goal_col_ff};
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      cfg.side      = side_ff;
      cfg.start_row = pwdata[POS_W-1:0];
      cfg.start_col = pwdata[POS_W-1:0];
      cfg.goal_row  = goal_row_ff;
      cfg.goal_col  = goal_col_ff;
      cfg.load_row  = wr && (reg_idx == REG_START_ROW);
      cfg.load_col  = wr && (reg_idx == REG_START_COL);
   end

   mdfs_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_free_up      (req_free_up),
      .req_free_left    (req_free_left),
      .req_free_down    (req_free_down),
      .req_free_right   (req_free_right),
      .req_random_value (req_random_value),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_word           (front_word)
   );

   mdfs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (front_word),
      .pop       (q_pop),
      .head_word (head_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   mdfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_word          (head_word),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_move_dir    (rsp_move_dir),
      .rsp_moved       (rsp_moved),
      .rsp_backtracked (rsp_backtracked),
      .rsp_new_row     (rsp_new_row),
      .rsp_new_col     (rsp_new_col),
      .rsp_at_goal     (rsp_at_goal),
      .rsp_stuck       (rsp_stuck)
   );

endmodule

`default_nettype wire
